@@ sv/bsm_pkg.sv @@
// Package with shared types and constants for the bounding sphere merge block.
package bsm_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQ,
        ST_SQRT,
        ST_TEST,
        ST_MUL,
        ST_DIV,
        ST_UPD,
        ST_OUT
    } bsm_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic load_first;
        logic do_diff;
        logic sq_step;
        logic sqrt_start;
        logic sqrt_step;
        logic do_test;
        logic mul_step;
        logic div_start;
        logic div_step;
        logic do_merge;
        logic do_replace;
        logic load_out;
    } bsm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sq_done;
        logic sqrt_done;
        logic keep;
        logic replace;
        logic mul_done;
        logic div_done;
    } bsm_stat_t;

endpackage

@@ sv/bsm_ctrl.sv @@
// Controller state machine that sequences one sphere through the datapath.
module bsm_ctrl
    import bsm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic      s_tlast,
    input  logic      out_full,
    input  bsm_stat_t stat,
    output bsm_cmd_t  cmd
);

    bsm_state_t state_reg, state_next;
    logic first_reg, first_next;
    logic last_reg, last_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            first_reg <= 1'b1;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            first_reg <= first_next;
            last_reg  <= last_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        first_next = first_reg;
        last_next  = last_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    last_next   = s_tlast;
                    if (first_reg) begin
                        cmd.load_first = 1'b1;
                        first_next     = 1'b0;
                        state_next     = s_tlast ? ST_OUT : ST_IDLE;
                    end else begin
                        state_next = ST_DIFF;
                    end
                end
            end
            ST_DIFF: begin
                cmd.do_diff = 1'b1;
                state_next  = ST_SQ;
            end
            ST_SQ: begin
                cmd.sq_step = 1'b1;
                if (stat.sq_done) begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_SQRT;
                end
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (stat.sqrt_done) state_next = ST_TEST;
            end
            ST_TEST: begin
                cmd.do_test = 1'b1;
                state_next  = ST_MUL;
            end
            ST_MUL: begin
                if (stat.keep) begin
                    state_next = last_reg ? ST_OUT : ST_IDLE;
                end else if (stat.replace) begin
                    cmd.do_replace = 1'b1;
                    state_next     = last_reg ? ST_OUT : ST_IDLE;
                end else begin
                    cmd.mul_step = 1'b1;
                    if (stat.mul_done) begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.do_merge = 1'b1;
                state_next   = last_reg ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (!out_full) begin
                    cmd.load_out = 1'b1;
                    first_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // The output register is only written when it is free.
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !out_full) else $error("output overwritten");
    // An input beat is only taken in the idle state.
    a_in_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_in |-> state_reg == ST_IDLE) else $error("beat taken while busy");
    // A merge follows a finished division.
    a_merge: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_merge |-> $past(stat.div_done)) else $error("merge without quotient");

endmodule

@@ sv/bsm_dp.sv @@
// Datapath: kept sphere, squares, square root, products and divider.
module bsm_dp
    import bsm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    input  logic signed [31:0] in_z,
    input  logic        [30:0] in_r,
    input  bsm_cmd_t           cmd,
    output bsm_stat_t          stat,
    output logic signed [31:0] res_x,
    output logic signed [31:0] res_y,
    output logic signed [31:0] res_z,
    output logic        [30:0] res_r
);

    // The integer arithmetic scales alike for any fraction width.
    localparam int UNUSED_FRAC = FRAC_BITS;

    logic signed [31:0] kc_reg [3];
    logic        [30:0] kr_reg;
    logic signed [31:0] nc_reg [3];
    logic        [30:0] nr_reg;
    logic signed [32:0] diff_reg [3];
    logic        [31:0] mag_reg [3];
    logic        [1:0]  idx_reg;
    logic        [65:0] sum_reg;
    // Square root, one result bit a step.
    logic        [67:0] rem_reg;
    logic        [34:0] root_reg;
    logic        [5:0]  cnt_reg;
    logic               keep_reg, repl_reg;
    logic        [63:0] prod_reg [3];
    // Divider, three lanes share one bit counter.
    logic        [63:0] quo_reg [3];
    logic        [34:0] drem_reg [3];

    logic [31:0] sq_mag;
    logic [63:0] sq_val;
    assign sq_mag = mag_reg[idx_reg];
    assign sq_val = sq_mag * sq_mag;

    logic [69:0] sr_try;
    logic [67:0] sr_rem;
    always_comb begin
        sr_rem = {rem_reg[65:0], sum_reg[65:64]};
        sr_try = {2'b0, sr_rem} - {33'b0, root_reg, 2'b01};
    end

    logic [35:0] d_ext;
    logic [31:0] rmag;
    assign d_ext = {1'b0, root_reg};
    assign rmag  = ($signed({1'b0, nr_reg}) >= $signed({1'b0, kr_reg})) ?
                   {1'b0, nr_reg - kr_reg} : {1'b0, kr_reg - nr_reg};

    function automatic logic signed [31:0] merge_c(input int i);
        logic signed [66:0] t, s;
        logic neg;
        begin
            neg = (nr_reg < kr_reg) != diff_reg[i][32];
            t = neg ? -$signed({3'b0, quo_reg[i]}) : $signed({3'b0, quo_reg[i]});
            if (root_reg == '0) t = '0;
            s = (67'(kc_reg[i]) + 67'(nc_reg[i]) + t) >>> 1;
            if (s > 67'sd2147483647) merge_c = 32'h7fffffff;
            else if (s < -67'sd2147483648) merge_c = 32'h80000000;
            else merge_c = s[31:0];
        end
    endfunction

    function automatic logic [30:0] merge_r();
        logic [36:0] s;
        begin
            s = ({2'b0, root_reg} + {6'b0, kr_reg} + {6'b0, nr_reg}) >> 1;
            merge_r = (s > 37'h7fffffff) ? 31'h7fffffff : s[30:0];
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) kc_reg[i] <= '0;
            kr_reg <= '0;
        end else begin
            if (cmd.load_first || cmd.do_replace) begin
                for (int i = 0; i < 3; i++) kc_reg[i] <= cmd.load_first ?
                    (i == 0 ? in_x : i == 1 ? in_y : in_z) : nc_reg[i];
                kr_reg <= cmd.load_first ? in_r : nr_reg;
            end
            if (cmd.do_merge) begin
                for (int i = 0; i < 3; i++) kc_reg[i] <= merge_c(i);
                kr_reg <= merge_r();
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            nc_reg[0] <= in_x;
            nc_reg[1] <= in_y;
            nc_reg[2] <= in_z;
            nr_reg    <= in_r;
        end
        if (cmd.do_diff) begin
            for (int i = 0; i < 3; i++) begin
                diff_reg[i] <= 33'(nc_reg[i]) - 33'(kc_reg[i]);
                mag_reg[i]  <= (nc_reg[i] >= kc_reg[i]) ?
                    32'(nc_reg[i] - kc_reg[i]) : 32'(kc_reg[i] - nc_reg[i]);
            end
            idx_reg <= '0;
            sum_reg <= '0;
        end
        if (cmd.sq_step) begin
            sum_reg <= sum_reg + {2'b0, sq_val};
            idx_reg <= idx_reg + 2'd1;
        end
        if (cmd.sqrt_start) begin
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
        end
        if (cmd.sqrt_step) begin
            sum_reg <= {sum_reg[63:0], 2'b00};
            cnt_reg <= cnt_reg + 6'd1;
            if (!sr_try[69]) begin
                rem_reg  <= sr_try[67:0];
                root_reg <= {root_reg[33:0], 1'b1};
            end else begin
                rem_reg  <= sr_rem;
                root_reg <= {root_reg[33:0], 1'b0};
            end
        end
        if (cmd.do_test) begin
            keep_reg <= (d_ext + 36'(nr_reg)) <= 36'(kr_reg);
            repl_reg <= (d_ext + 36'(kr_reg)) <= 36'(nr_reg);
            idx_reg  <= '0;
        end
        if (cmd.mul_step) begin
            prod_reg[idx_reg] <= rmag * mag_reg[idx_reg];
            idx_reg <= idx_reg + 2'd1;
        end
        if (cmd.div_start) cnt_reg <= '0;
        if (cmd.div_step) begin
            cnt_reg <= cnt_reg + 6'd1;
            for (int i = 0; i < 3; i++) begin
                logic [35:0] dr;
                logic [63:0] q;
                q  = (cnt_reg == '0) ? prod_reg[i] : quo_reg[i];
                dr = {(cnt_reg == '0) ? 35'd0 : drem_reg[i], q[63]};
                if (dr >= d_ext) begin
                    drem_reg[i] <= 35'(dr - d_ext);
                    quo_reg[i]  <= {q[62:0], 1'b1};
                end else begin
                    drem_reg[i] <= dr[34:0];
                    quo_reg[i]  <= {q[62:0], 1'b0};
                end
            end
        end
        if (cmd.load_out) begin
            res_x <= kc_reg[0];
            res_y <= kc_reg[1];
            res_z <= kc_reg[2];
            res_r <= kr_reg;
        end
    end

    always_comb begin
        stat.sq_done   = (idx_reg == 2'd2);
        stat.sqrt_done = (cnt_reg == 6'd32);
        stat.keep      = keep_reg;
        stat.replace   = repl_reg;
        stat.mul_done  = (idx_reg == 2'd2);
        stat.div_done  = (cnt_reg == 6'd63) || (UNUSED_FRAC < 0);
    end

endmodule

@@ sv/bounding_sphere_merge.sv @@
// Top level of the bounding sphere merge block.
// A merging sphere passes through 3 squares, 33 root steps, 3 products and 64 divider
// steps; a contained or containing sphere ends after the containment test.
// Spheres are handled one at a time: s_tready is high only in the idle state, and after
// a last beat the output register is loaded once it is free and then waits for m_tready.
// Reset (aresetn low, synchronous) clears the kept sphere, sets the first flag and
// empties the output register.
module bounding_sphere_merge
    import bsm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // center_x, center_y, center_z, radius, pad
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // merged_x, merged_y, merged_z, merged_radius, pad
);

    bsm_cmd_t  cmd;
    bsm_stat_t stat;
    logic      full_reg;
    logic signed [31:0] rx, ry, rz;
    logic [30:0] rr;

    bsm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tlast(s_tlast), .out_full(full_reg), .stat(stat), .cmd(cmd)
    );

    bsm_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .in_x(s_tdata[31:0]), .in_y(s_tdata[63:32]), .in_z(s_tdata[95:64]),
        .in_r(s_tdata[126:96]), .cmd(cmd), .stat(stat),
        .res_x(rx), .res_y(ry), .res_z(rz), .res_r(rr)
    );

    // Output register occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) full_reg <= 1'b0;
        else if (cmd.load_out) full_reg <= 1'b1;
        else if (m_tready) full_reg <= 1'b0;
    end

    assign m_tvalid = full_reg;
    assign m_tdata  = {1'b0, rr, rz, ry, rx};

endmodule
